// ===== rtl/core/keypad_scan_beep_display_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared concurrent assertion shorthands for the keypad scanner checkers.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_BEEP_DISPLAY_UNIT_DEFINES_SVH
`define KEYPAD_SCAN_BEEP_DISPLAY_UNIT_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define KSBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define KSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ksbd_pkg.sv =====
// ---------------------------------------------------------------------------
// Keypad scanner package
// Phase codes, register indexes, result layout and display patterns.
// ---------------------------------------------------------------------------
package ksbd_pkg;

	localparam logic [2:0] PH_ALL      = 3'd0;
	localparam logic [2:0] PH_DEBOUNCE = 3'd1;
	localparam logic [2:0] PH_PROBE    = 3'd2;
	localparam logic [2:0] PH_RELEASE  = 3'd3;
	localparam logic [2:0] PH_BEEP     = 3'd4;

	localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
	localparam logic [1:0] REG_BEEP_HALF   = 2'd1;
	localparam logic [1:0] REG_BEEP_CYCLES = 2'd2;

	localparam logic [3:0] COLS_IDLE = 4'hf;
	localparam logic [7:0] SEG_DASH  = 8'hbf;

	localparam int RESULT_W = 17;
	localparam int TDATA_W  = 24;

	// Packed MSB first: row_drive lands in the lowest bits of tdata.
	typedef struct packed {
		logic [3:0] key_code;
		logic       beeper;
		logic [7:0] segments;
		logic [3:0] row_drive;
	} result_t;

	// Common-anode digit patterns, active low, hex digits 0..f.
	function automatic logic [7:0] seg_pattern(input logic [3:0] k);
		logic [7:0] p;
		case (k)
			4'h0: p = 8'hc0;
			4'h1: p = 8'hf9;
			4'h2: p = 8'ha4;
			4'h3: p = 8'hb0;
			4'h4: p = 8'h99;
			4'h5: p = 8'h92;
			4'h6: p = 8'h82;
			4'h7: p = 8'hf8;
			4'h8: p = 8'h80;
			4'h9: p = 8'h90;
			4'ha: p = 8'h88;
			4'hb: p = 8'h83;
			4'hc: p = 8'hc6;
			4'hd: p = 8'ha1;
			4'he: p = 8'h86;
			default: p = 8'h8e;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/core/keypad_scan_beep_display_unit.sv =====
// ---------------------------------------------------------------------------
// Keypad scanner with key beep and seven-segment display
// 4x4 matrix scan with debounce, release wait and beep burst per key.
// ---------------------------------------------------------------------------
//
//  channel   | direction | tdata bits (low first)                      | tuser
//  ----------+-----------+---------------------------------------------+------
//  s_t*      | in        | [3:0] column_sense, [7:4] zero              | none
//  m_t*      | out       | [3:0] row_drive, [11:4] segments,           | none
//            |           | [12] beeper, [16:13] key_code, [23:17] zero |
//  cfg_*     | in        | cfg_index 0 debounce, 1 beep half, 2 burst  | none
//
// Cycles: one tick per transfer; a tick may follow every
//   cycle while s_tready is high. The scan state machine and the result
//   register (or the skid, if stalled) are updated in the cycle of the input transfer.
// Stalls: a two-entry output buffer (result register plus skid) lets one more
//   tick be taken while a result waits; s_tready drops only once both are full.
// Reset: arst_n clears the scan to the all-rows check, display to a dash,
//   beeper high, key zero and registers to 1000 / 50 / 50.
//
module keypad_scan_beep_display_unit (
	input  logic        clk,
	input  logic        arst_n,
	// column tick in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] column_sense, [7:4] zero
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] row_drive, [11:4] segments,
	                               // [12] beeper, [16:13] key_code, rest zero
	// register writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [15:0] debounce_q;
	logic [15:0] beep_half_q;
	logic [7:0]  beep_cycles_q;

	// scan state
	logic [2:0]  phase_q,  phase_d;
	logic [1:0]  row_q,    row_d;
	logic [3:0]  key_q,    key_d;
	logic [15:0] tick_q,   tick_d;
	logic [7:0]  period_q, period_d;
	logic [7:0]  seg_q,    seg_d;
	logic        beep_q,   beep_d;

	// output buffer
	ksbd_pkg::result_t res_q, skid_q, res_d;
	logic              res_valid_q, skid_valid_q;

	logic        accept;
	logic        load_out;
	logic [3:0]  cols;
	logic [15:0] tick_inc;
	logic [7:0]  period_inc;
	logic        row_end;

	assign cols     = s_tdata[3:0];
	assign accept   = s_tvalid && s_tready;
	assign s_tready = !skid_valid_q;
	assign load_out = !res_valid_q || m_tready;

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {{(ksbd_pkg::TDATA_W - ksbd_pkg::RESULT_W){1'b0}}, res_q};

	// Register writes, taken at any edge; the block does not keep them clear of ticks in flight, the user must.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= 16'd1000;
			beep_half_q   <= 16'd50;
			beep_cycles_q <= 8'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				ksbd_pkg::REG_DEBOUNCE:    debounce_q    <= cfg_data;
				ksbd_pkg::REG_BEEP_HALF:   beep_half_q   <= cfg_data;
				ksbd_pkg::REG_BEEP_CYCLES: beep_cycles_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Next state for one tick. A zero half period gives one tick per half, as
	// any count reaches it; the zero test also ends a wait whose count wraps.
	always_comb begin
		phase_d    = phase_q;
		row_d      = row_q;
		key_d      = key_q;
		tick_d     = tick_q;
		period_d   = period_q;
		seg_d      = seg_q;
		beep_d     = beep_q;
		row_end    = 1'b0;
		tick_inc   = tick_q + 16'd1;
		period_inc = period_q + 8'd1;

		case (phase_q)
			ksbd_pkg::PH_DEBOUNCE: begin
				tick_d = tick_inc;
				if (tick_inc >= debounce_q || tick_inc == 16'd0) begin
					tick_d  = 16'd0;
					row_d   = 2'd0;
					phase_d = ksbd_pkg::PH_PROBE;
				end
			end
			ksbd_pkg::PH_PROBE: begin
				if (cols == ksbd_pkg::COLS_IDLE) begin
					row_end = 1'b1;
				end else begin
					// only a single low column decodes; several keep the old key
					case (cols)
						4'he: key_d = {row_q, 2'd0};
						4'hd: key_d = {row_q, 2'd1};
						4'hb: key_d = {row_q, 2'd2};
						4'h7: key_d = {row_q, 2'd3};
						default: ;
					endcase
					phase_d = ksbd_pkg::PH_RELEASE;
				end
			end
			ksbd_pkg::PH_RELEASE: begin
				if (cols == ksbd_pkg::COLS_IDLE) begin
					if (beep_cycles_q == 8'd0) begin
						row_end = 1'b1;
					end else begin
						tick_d   = 16'd0;
						period_d = 8'd0;
						beep_d   = 1'b0;
						phase_d  = ksbd_pkg::PH_BEEP;
					end
				end
			end
			ksbd_pkg::PH_BEEP: begin
				tick_d = tick_inc;
				if (tick_inc >= beep_half_q || tick_inc == 16'd0) begin
					tick_d = 16'd0;
					if (!beep_q) begin
						beep_d = 1'b1;
					end else begin
						period_d = period_inc;
						if (period_inc >= beep_cycles_q) begin
							period_d = 8'd0;
							row_end  = 1'b1;
						end else begin
							beep_d = 1'b0;
						end
					end
				end
			end
			default: begin
				// all-rows check; spare codes land here too
				tick_d = 16'd0;
				row_d  = 2'd0;
				if (cols != ksbd_pkg::COLS_IDLE && debounce_q != 16'd0) begin
					phase_d = ksbd_pkg::PH_DEBOUNCE;
				end else begin
					phase_d = ksbd_pkg::PH_PROBE;
				end
			end
		endcase

		// step to next row; after row 3 the pass ends and the display updates
		if (row_end) begin
			if (row_q == 2'd3) begin
				row_d   = 2'd0;
				seg_d   = ksbd_pkg::seg_pattern(key_q);
				phase_d = ksbd_pkg::PH_ALL;
			end else begin
				row_d   = row_q + 2'd1;
				phase_d = ksbd_pkg::PH_PROBE;
			end
		end

		res_d.key_code = key_d;
		res_d.beeper   = beep_d;
		res_d.segments = seg_d;
		if (phase_d inside {ksbd_pkg::PH_PROBE, ksbd_pkg::PH_RELEASE, ksbd_pkg::PH_BEEP}) begin
			res_d.row_drive = ~(4'b0001 << row_d);
		end else begin
			res_d.row_drive = 4'b0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ksbd_pkg::PH_ALL;
			row_q    <= 2'd0;
			key_q    <= 4'd0;
			tick_q   <= 16'd0;
			period_q <= 8'd0;
			seg_q    <= ksbd_pkg::SEG_DASH;
			beep_q   <= 1'b1;
		end else if (accept) begin
			phase_q  <= phase_d;
			row_q    <= row_d;
			key_q    <= key_d;
			tick_q   <= tick_d;
			period_q <= period_d;
			seg_q    <= seg_d;
			beep_q   <= beep_d;
		end
	end

	// Output buffer valids. The skid only fills while the result register is
	// stalled, and drains into it first, so order is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (accept) begin
				res_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

endmodule

// ===== rtl/core/ksbd_checker.sv =====
// ---------------------------------------------------------------------------
// Keypad scanner port checker
// Port-level checks on the result stream and input ready, bound to the top level.
// ---------------------------------------------------------------------------
`include "keypad_scan_beep_display_unit_defines.svh"

module ksbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	ksbd_pkg::result_t res;

	assign res = m_tdata[ksbd_pkg::RESULT_W-1:0];

	// a stalled result holds
	`KSBD_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// rows are either all driven or exactly one probed
	`KSBD_ASSERT_NOW(a_row_shape, clk, arst_n, m_tvalid, res.row_drive == 4'b0000 || $countones(res.row_drive) == 3, "bad row drive pattern")

	// the beeper sounds only while a single row is held
	`KSBD_ASSERT_NOW(a_beep_row, clk, arst_n, m_tvalid && !res.beeper, res.row_drive != 4'b0000, "beep outside a probed row")

	// input back-pressure only when a result is waiting
	`KSBD_ASSERT_NOW(a_ready_backpressure, clk, arst_n, !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

bind keypad_scan_beep_display_unit ksbd_checker u_ksbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/keypad_scan_beep_display_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keypad scanner testbench
// Feeds column ticks over the input stream and mirrors the scan, debounce,
// release wait, beep burst and display update in a local scan model. Every
// output transfer is checked field by field against the oldest prediction.
// Register settings change between runs of ticks.
// ---------------------------------------------------------------------------
module keypad_scan_beep_display_unit_tb;

	localparam int PHASE_ITEMS = 115;   // random ticks per register setting
	localparam int RAND_PHASES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;       // [3:0] column_sense, [7:4] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;               // [3:0] row_drive, [11:4] segments,
	                                    // [12] beeper, [16:13] key_code
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'h0000;

	keypad_scan_beep_display_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// -----------------------------------------------------------------------
	// Scan model state and register copies
	// -----------------------------------------------------------------------
	logic [2:0]  scan_phase  = ksbd_pkg::PH_ALL;
	logic [1:0]  scan_row    = 2'd0;
	logic [3:0]  scan_key    = 4'd0;
	logic [15:0] scan_ticks  = 16'd0;
	logic [7:0]  scan_beeps  = 8'd0;
	logic [7:0]  scan_seg    = ksbd_pkg::SEG_DASH;
	logic        scan_beeper = 1'b1;

	logic [15:0] debounce_len = 16'd1000;
	logic [15:0] half_len     = 16'd50;
	logic [7:0]  burst_len    = 8'd50;

	// Digit patterns, common anode, active low
	logic [7:0] digit_seg [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
	};

	// Directed ticks. First run: zero debounce, zero beeps, single- and
	// multi-low patterns across rows. Second: short debounce, zero half
	// period (one tick per half), two beep periods.
	logic [3:0] quick_cols [9] = '{
		4'he, 4'he, 4'hf, 4'hd, 4'hf, 4'h0, 4'hf, 4'h7, 4'hf
	};
	logic [3:0] beep_cols [11] = '{
		4'hb, 4'hb, 4'hb, 4'hb, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf
	};

	// Register settings for the random runs. The 65535 extremes leave the
	// scan mid-wait; the following setting then cuts the wait short.
	logic [15:0] set_debounce [RAND_PHASES] = '{
		16'd1, 16'd0, 16'd3, 16'hffff, 16'd2, 16'd0, 16'd5, 16'd1
	};
	logic [15:0] set_half [RAND_PHASES] = '{
		16'd1, 16'd2, 16'd1, 16'd1, 16'hffff, 16'd0, 16'd3, 16'd1
	};
	logic [7:0] set_burst [RAND_PHASES] = '{
		8'd1, 8'd3, 8'd0, 8'd255, 8'd1, 8'd2, 8'd1, 8'd2
	};

	logic [3:0]        column_ticks [$];       // ticks waiting to be sent
	ksbd_pkg::result_t predicted_scan [$];     // results owed by the block
	int                mismatches = 0;

	bit in_fire  = 1'b0;                // input transfer at the last rising edge
	bit out_fire = 1'b0;                // output transfer at the last rising edge
	int send_wait  = 0;
	int send_quiet = 0;
	int recv_wait  = 0;
	int recv_quiet = 0;

	// -----------------------------------------------------------------------
	// Scan model
	// -----------------------------------------------------------------------

	// End of a probed row: step to the next one, or close the pass and show
	// the key on the display.
	function automatic void finish_row();
		if (scan_row == 2'd3) begin
			scan_row   = 2'd0;
			scan_seg   = digit_seg[scan_key];
			scan_phase = ksbd_pkg::PH_ALL;
		end else begin
			scan_row   = scan_row + 2'd1;
			scan_phase = ksbd_pkg::PH_PROBE;
		end
	endfunction

	// One tick of the keypad scan; returns the result it produces.
	function automatic ksbd_pkg::result_t scan_tick(input logic [3:0] cols);
		ksbd_pkg::result_t r;
		case (scan_phase)
			ksbd_pkg::PH_DEBOUNCE: begin
				scan_ticks = scan_ticks + 16'd1;
				if (scan_ticks >= debounce_len || scan_ticks == 16'd0) begin
					scan_ticks = 16'd0;
					scan_row   = 2'd0;
					scan_phase = ksbd_pkg::PH_PROBE;
				end
			end
			ksbd_pkg::PH_PROBE: begin
				if (cols == ksbd_pkg::COLS_IDLE) begin
					finish_row();
				end else begin
					// only a single low column decodes; anything else keeps the key
					case (cols)
						4'he: scan_key = {scan_row, 2'd0};
						4'hd: scan_key = {scan_row, 2'd1};
						4'hb: scan_key = {scan_row, 2'd2};
						4'h7: scan_key = {scan_row, 2'd3};
						default: ;
					endcase
					scan_phase = ksbd_pkg::PH_RELEASE;
				end
			end
			ksbd_pkg::PH_RELEASE: begin
				if (cols == ksbd_pkg::COLS_IDLE) begin
					if (burst_len == 8'd0) begin
						finish_row();
					end else begin
						scan_ticks  = 16'd0;
						scan_beeps  = 8'd0;
						scan_beeper = 1'b0;
						scan_phase  = ksbd_pkg::PH_BEEP;
					end
				end
			end
			ksbd_pkg::PH_BEEP: begin
				// zero half period: any count reaches it, one tick per half
				scan_ticks = scan_ticks + 16'd1;
				if (scan_ticks >= half_len || scan_ticks == 16'd0) begin
					scan_ticks = 16'd0;
					if (!scan_beeper) begin
						scan_beeper = 1'b1;
					end else begin
						scan_beeps = scan_beeps + 8'd1;
						if (scan_beeps >= burst_len) begin
							scan_beeps = 8'd0;
							finish_row();
						end else begin
							scan_beeper = 1'b0;
						end
					end
				end
			end
			default: begin
				// all-rows check; spare phase codes land here as well
				scan_ticks = 16'd0;
				scan_row   = 2'd0;
				if (cols != ksbd_pkg::COLS_IDLE && debounce_len != 16'd0)
					scan_phase = ksbd_pkg::PH_DEBOUNCE;
				else
					scan_phase = ksbd_pkg::PH_PROBE;
			end
		endcase

		if (scan_phase == ksbd_pkg::PH_PROBE || scan_phase == ksbd_pkg::PH_RELEASE
				|| scan_phase == ksbd_pkg::PH_BEEP)
			r.row_drive = ~(4'b0001 << scan_row);
		else
			r.row_drive = 4'h0;
		r.segments = scan_seg;
		r.beeper   = scan_beeper;
		r.key_code = scan_key;
		return r;
	endfunction

	// Idle length for one item: mostly a short random pause, with the odd calm
	// stretch of back-to-back items.
	function automatic int pause_len(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	// -----------------------------------------------------------------------
	// Clock, reset and watchdog
	// -----------------------------------------------------------------------
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// A run that overruns the watchdog ends with an error.
	initial begin
		#200000;
		$display("RESULT: ERROR");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Transfer sampling, prediction and checking at the rising edge
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		ksbd_pkg::result_t want;
		ksbd_pkg::result_t got;
		in_fire  = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;

		// check before predicting: a result always trails its tick, so its prediction is already queued
		if (out_fire) begin
			got = m_tdata[ksbd_pkg::RESULT_W-1:0];
			if (predicted_scan.size() == 0) begin
				$error("unexpected result transfer, tdata %h", m_tdata);
				mismatches++;
			end else begin
				want = predicted_scan.pop_front();
				if (got.row_drive !== want.row_drive) begin
					$error("row_drive: expected %h, got %h", want.row_drive, got.row_drive);
					mismatches++;
				end
				if (got.segments !== want.segments) begin
					$error("segments: expected %h, got %h", want.segments, got.segments);
					mismatches++;
				end
				if (got.beeper !== want.beeper) begin
					$error("beeper: expected %b, got %b", want.beeper, got.beeper);
					mismatches++;
				end
				if (got.key_code !== want.key_code) begin
					$error("key_code: expected %h, got %h", want.key_code, got.key_code);
					mismatches++;
				end
				if (m_tdata[ksbd_pkg::TDATA_W-1:ksbd_pkg::RESULT_W] !== '0) begin
					$error("tdata padding: expected 0, got %h",
						m_tdata[ksbd_pkg::TDATA_W-1:ksbd_pkg::RESULT_W]);
					mismatches++;
				end
			end
		end

		if (in_fire)
			predicted_scan.push_back(scan_tick(s_tdata[3:0]));
	end

	// -----------------------------------------------------------------------
	// Tick driver: presents the next queued column sample after its gap
	// -----------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (in_fire)
				send_wait = pause_len(send_quiet);
			if (send_wait > 0) begin
				send_wait--;
				s_tvalid <= 1'b0;
			end else if (column_ticks.size() != 0) begin
				s_tdata  <= {4'h0, column_ticks.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result sink: stalls for a random pause after each transfer
	// -----------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				recv_wait = pause_len(recv_quiet);
			if (out_fire || !m_tready) begin
				if (recv_wait > 0) begin
					recv_wait--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sequencing
	// -----------------------------------------------------------------------

	// Block is quiet: nothing queued, nothing on the bus, nothing owed.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (column_ticks.size() != 0 || s_tvalid || predicted_scan.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			ksbd_pkg::REG_DEBOUNCE:    debounce_len = val;
			ksbd_pkg::REG_BEEP_HALF:   half_len     = val;
			ksbd_pkg::REG_BEEP_CYCLES: burst_len    = val[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] deb, input logic [15:0] half,
			input logic [7:0] burst);
		write_reg(ksbd_pkg::REG_DEBOUNCE, deb);
		write_reg(ksbd_pkg::REG_BEEP_HALF, half);
		write_reg(ksbd_pkg::REG_BEEP_CYCLES, {8'h00, burst});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed presses (hold then release), some idle stretches,
	// some fully random column noise.
	task automatic queue_keypad(input int count);
		int         added;
		int         pick;
		int         hold;
		logic [3:0] pattern;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if ($urandom_range(0, 9) != 0)
					pattern = ~(4'b0001 << $urandom_range(0, 3));
				else
					pattern = 4'($urandom_range(0, 14));   // any low pattern, often multi-low
				hold = $urandom_range(1, 12);
				repeat (hold) column_ticks.push_back(pattern);
				added += hold;
				hold = $urandom_range(1, 15);
				repeat (hold) column_ticks.push_back(ksbd_pkg::COLS_IDLE);
				added += hold;
			end else if (pick < 9) begin
				hold = $urandom_range(1, 20);
				repeat (hold) column_ticks.push_back(ksbd_pkg::COLS_IDLE);
				added += hold;
			end else begin
				hold = $urandom_range(1, 8);
				repeat (hold) column_ticks.push_back(4'($urandom_range(0, 15)));
				added += hold;
			end
		end
	endtask

	initial begin
		@(posedge arst_n);

		// directed: zero debounce, zero half period, zero beep periods
		apply_settings(16'd0, 16'd0, 8'd0);
		foreach (quick_cols[i]) column_ticks.push_back(quick_cols[i]);
		wait_drained();

		apply_settings(16'd2, 16'd0, 8'd2);
		foreach (beep_cols[i]) column_ticks.push_back(beep_cols[i]);
		wait_drained();

		// random runs; each halts midway until every result is back
		for (int p = 0; p < RAND_PHASES; p++) begin
			apply_settings(set_debounce[p], set_half[p], set_burst[p]);
			queue_keypad(PHASE_ITEMS / 2);
			wait_drained();
			queue_keypad(PHASE_ITEMS - PHASE_ITEMS / 2);
			wait_drained();
		end

		// idle cycles at the end catch any stray transfer
		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_scan.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== keypad_scan_beep_display_unit.f =====
+incdir+rtl/core
rtl/core/ksbd_pkg.sv
rtl/core/keypad_scan_beep_display_unit.sv
rtl/core/ksbd_checker.sv
tb/keypad_scan_beep_display_unit_tb.sv
